@@ design/graphic_equalizer_bandpass_cascade_macros.svh @@
// ----------------------------------------------------------------------------
// Equalizer assertion macros
// Shared concurrent assertion forms used by the equalizer RTL.
// ----------------------------------------------------------------------------
`ifndef GRAPHIC_EQUALIZER_BANDPASS_CASCADE_MACROS_SVH
`define GRAPHIC_EQUALIZER_BANDPASS_CASCADE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GEQ_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/geq_pkg.sv @@
// ----------------------------------------------------------------------------
// Equalizer package
// Payload types, operation codes, controller states and fixed-point helpers.
// ----------------------------------------------------------------------------
package geq_pkg;

	// Request function codes.
	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_COEF   = 2'd1,
		FUNC_GAIN   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// Coefficient select codes.
	typedef enum logic [1:0] {
		SEL_A0   = 2'd0,
		SEL_A1   = 2'd1,
		SEL_B0   = 2'd2,
		SEL_NONE = 2'd3
	} coef_sel_t;

	typedef struct packed {
		func_t              func;
		logic [2:0]         channel;
		logic [3:0]         band;
		coef_sel_t          coef_select;
		logic signed [31:0] value;
		logic signed [23:0] sample_in;
	} in_t;

	typedef struct packed {
		logic signed [23:0] sample_out;
		logic [2:0]         out_channel;
		logic               clipped;
	} out_t;

	typedef logic [3:0] cfg_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_WT0,
		ST_WT1,
		ST_MG,
		ST_WG0,
		ST_WG1,
		ST_WB,
		ST_OUT
	} state_t;

	// Multiplier operand selects.
	typedef enum logic [1:0] {OPA_X, OPA_H0, OPA_H1, OPA_T} opa_t;
	typedef enum logic [2:0] {OPC_B0, OPC_A0, OPC_A1, OPC_DAMP, OPC_GAIN} opc_t;

	// What happens to a product when it leaves the multiplier pipeline.
	typedef enum logic [2:0] {TAG_NONE, TAG_W0, TAG_W1, TAG_W2, TAG_T, TAG_X} tag_t;

	typedef struct packed {
		logic capture;
		logic wr_coef;
		logic wr_gain;
		logic start;
		logic rd;
		logic wb;
		logic out_load;
		opa_t opa;
		opc_t opc;
		tag_t tag;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  skip;
		logic  band_last;
		logic  out_free;
	} status_t;

	// Damping constant -1.0050 in Q3.28.
	localparam logic signed [31:0] DAMP_COEF = -32'sd269777633;

	localparam logic signed [44:0] MAX40 = 45'sd549755813887;
	localparam logic signed [44:0] MIN40 = -45'sd549755813888;

	// Overflow test of a wide value against the 40-bit internal range.
	function automatic logic ovf40(input logic signed [44:0] v);
		return (v > MAX40) || (v < MIN40);
	endfunction

	// Saturate a wide value to the 40-bit internal range.
	function automatic logic signed [39:0] sat40(input logic signed [44:0] v);
		logic signed [39:0] r;
		if (v > MAX40) begin
			r = MAX40[39:0];
		end else if (v < MIN40) begin
			r = MIN40[39:0];
		end else begin
			r = v[39:0];
		end
		return r;
	endfunction

endpackage

@@ design/geq_stream_if.sv @@
// ----------------------------------------------------------------------------
// Equalizer stream interface
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface geq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/graphic_equalizer_bandpass_cascade.sv @@
// ----------------------------------------------------------------------------
// Graphic equalizer band-pass cascade
// Per-channel cascade of band-pass sections with saturating fixed-point math.
// ----------------------------------------------------------------------------
// A sample request runs one band pass per active band: the register value,
// at most MAX_BANDS, or none for a channel beyond MAX_CHANNELS. Coefficient
// and gain writes and an unknown function code run no band pass. Each band
// reads its history, coefficients and gain, issues five products into a
// single two-stage multiplier pipeline and writes its history back; the gain
// product waits for the damped feedback term and the next band waits for the
// updated sample. The result sits in an output register, so a new request is
// accepted while it waits. All stores read as zero after reset without a
// clearing pass.
// ----------------------------------------------------------------------------
module graphic_equalizer_bandpass_cascade #(
	parameter int MAX_BANDS    = 10,
	parameter int MAX_CHANNELS = 8
) (
	input logic         clk,
	input logic         arst_n,
	geq_stream_if.sink   sample_ch,
	geq_stream_if.source result_ch,
	geq_stream_if.sink   cfg
);

	geq_pkg::cmd_t    cmd;
	geq_pkg::status_t status;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	geq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample_ch.valid),
		.in_ready(sample_ch.ready),
		.status(status),
		.cmd(cmd)
	);

	geq_datapath #(
		.MAX_BANDS(MAX_BANDS),
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(sample_ch.data),
		.cmd(cmd),
		.status(status),
		.cfg_valid(cfg.valid),
		.cfg_data(cfg.data),
		.out_valid(result_ch.valid),
		.out_ready(result_ch.ready),
		.out_data(result_ch.data)
	);

endmodule

@@ design/geq_ram.sv @@
// ----------------------------------------------------------------------------
// Equalizer RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module geq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/geq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Equalizer controller
// Sequences requests, band passes and multiplier issue for the datapath.
// ----------------------------------------------------------------------------
module geq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  geq_pkg::status_t status,
	output geq_pkg::cmd_t    cmd
);

	geq_pkg::state_t state_q, state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= geq_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			geq_pkg::ST_IDLE: begin
				if (in_valid) state_next = geq_pkg::ST_DECODE;
			end
			geq_pkg::ST_DECODE: begin
				if (status.func == geq_pkg::FUNC_SAMPLE) begin
					state_next = status.skip ? geq_pkg::ST_OUT : geq_pkg::ST_READ;
				end else begin
					state_next = geq_pkg::ST_IDLE;
				end
			end
			geq_pkg::ST_READ: state_next = geq_pkg::ST_M0;
			geq_pkg::ST_M0:   state_next = geq_pkg::ST_M1;
			geq_pkg::ST_M1:   state_next = geq_pkg::ST_M2;
			geq_pkg::ST_M2:   state_next = geq_pkg::ST_M3;
			geq_pkg::ST_M3:   state_next = geq_pkg::ST_WT0;
			geq_pkg::ST_WT0:  state_next = geq_pkg::ST_WT1;
			geq_pkg::ST_WT1:  state_next = geq_pkg::ST_MG;
			geq_pkg::ST_MG:   state_next = geq_pkg::ST_WG0;
			geq_pkg::ST_WG0:  state_next = geq_pkg::ST_WG1;
			geq_pkg::ST_WG1:  state_next = geq_pkg::ST_WB;
			geq_pkg::ST_WB: begin
				state_next = status.band_last ? geq_pkg::ST_OUT : geq_pkg::ST_READ;
			end
			geq_pkg::ST_OUT: begin
				if (status.out_free) state_next = geq_pkg::ST_IDLE;
			end
			default: state_next = geq_pkg::ST_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		cmd.opa  = geq_pkg::OPA_X;
		cmd.opc  = geq_pkg::OPC_B0;
		cmd.tag  = geq_pkg::TAG_NONE;
		unique case (state_q)
			geq_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			geq_pkg::ST_DECODE: begin
				unique case (status.func)
					geq_pkg::FUNC_SAMPLE: cmd.start   = 1'b1;
					geq_pkg::FUNC_COEF:   cmd.wr_coef = 1'b1;
					geq_pkg::FUNC_GAIN:   cmd.wr_gain = 1'b1;
					default: ;
				endcase
			end
			geq_pkg::ST_READ: cmd.rd = 1'b1;
			geq_pkg::ST_M0: begin
				cmd.opa = geq_pkg::OPA_X;
				cmd.opc = geq_pkg::OPC_B0;
				cmd.tag = geq_pkg::TAG_W0;
			end
			geq_pkg::ST_M1: begin
				cmd.opa = geq_pkg::OPA_H0;
				cmd.opc = geq_pkg::OPC_A0;
				cmd.tag = geq_pkg::TAG_W1;
			end
			geq_pkg::ST_M2: begin
				cmd.opa = geq_pkg::OPA_H1;
				cmd.opc = geq_pkg::OPC_A1;
				cmd.tag = geq_pkg::TAG_W2;
			end
			geq_pkg::ST_M3: begin
				cmd.opa = geq_pkg::OPA_H1;
				cmd.opc = geq_pkg::OPC_DAMP;
				cmd.tag = geq_pkg::TAG_T;
			end
			geq_pkg::ST_MG: begin
				cmd.opa = geq_pkg::OPA_T;
				cmd.opc = geq_pkg::OPC_GAIN;
				cmd.tag = geq_pkg::TAG_X;
			end
			geq_pkg::ST_WB:  cmd.wb = 1'b1;
			geq_pkg::ST_OUT: cmd.out_load = status.out_free;
			default: ;
		endcase
	end

endmodule

@@ design/geq_datapath.sv @@
// ----------------------------------------------------------------------------
// Equalizer datapath
// Stores, operand registers, shared multiplier pipeline and output register.
// ----------------------------------------------------------------------------
`include "graphic_equalizer_bandpass_cascade_macros.svh"

module geq_datapath #(
	parameter int MAX_BANDS    = 10,
	parameter int MAX_CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  geq_pkg::in_t     in_data,
	input  geq_pkg::cmd_t    cmd,
	output geq_pkg::status_t status,
	input  logic             cfg_valid,
	input  geq_pkg::cfg_t    cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output geq_pkg::out_t    out_data
);

	localparam int ROWS    = MAX_BANDS * MAX_CHANNELS;
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BAND_AW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam logic [4:0] NB_MAX = 5'(MAX_BANDS);
	localparam logic [4:0] NCH    = 5'(MAX_CHANNELS);
	localparam logic [ROW_AW-1:0] ROW_STRIDE = ROW_AW'(MAX_BANDS);
	localparam logic signed [72:0] ROUND_HALF = 73'sd134217728;

	geq_pkg::in_t item_q;
	logic [3:0]   active_bands_q;

	logic signed [39:0] x_q, w_q, t_q;
	logic signed [41:0] acc_q;
	logic               clip_q;
	logic [BAND_AW-1:0] k_q;
	logic [ROW_AW-1:0]  row_q;

	logic [ROWS-1:0]      hist_valid_q, gain_valid_q;
	logic [MAX_BANDS-1:0] a0_valid_q, a1_valid_q, b0_valid_q;
	logic                 hist_rv_q, gain_rv_q, a0_rv_q, a1_rv_q, b0_rv_q;

	logic signed [48:0] lo_s1;
	logic signed [55:0] hi_s1;
	geq_pkg::tag_t      tag_s1;
	logic signed [72:0] sum_s2;
	geq_pkg::tag_t      tag_s2;

	logic          out_valid_q;
	geq_pkg::out_t out_q;

	// Item decode.
	logic               ch_ok, band_ok;
	logic [4:0]         nb;
	logic [ROW_AW-1:0]  ch_row, gain_waddr;
	logic [BAND_AW-1:0] coef_waddr;

	assign ch_ok      = {2'b00, item_q.channel} < NCH;
	assign band_ok    = {1'b0, item_q.band} < NB_MAX;
	assign nb         = ({1'b0, active_bands_q} > NB_MAX) ? NB_MAX : {1'b0, active_bands_q};
	assign ch_row     = ROW_AW'(item_q.channel) * ROW_STRIDE;
	assign gain_waddr = ch_row + ROW_AW'(item_q.band);
	assign coef_waddr = item_q.band[BAND_AW-1:0];

	assign status.func      = item_q.func;
	assign status.skip      = !ch_ok || (nb == 5'd0);
	assign status.band_last = (5'(k_q) + 5'd1) == nb;
	assign status.out_free  = !out_valid_q || out_ready;

	// Stores.
	logic [79:0] hist_rd;
	logic [31:0] gain_rd, a0_rd, a1_rd, b0_rd;
	logic        we_gain, we_a0, we_a1, we_b0;
	logic signed [39:0] h0_eff, h1_eff;
	logic signed [31:0] gain_eff, a0_eff, a1_eff, b0_eff;

	assign we_gain = cmd.wr_gain && ch_ok && band_ok;
	assign we_a0   = cmd.wr_coef && band_ok && (item_q.coef_select == geq_pkg::SEL_A0);
	assign we_a1   = cmd.wr_coef && band_ok && (item_q.coef_select == geq_pkg::SEL_A1);
	assign we_b0   = cmd.wr_coef && band_ok && (item_q.coef_select == geq_pkg::SEL_B0);

	geq_ram #(.WIDTH(80), .DEPTH(ROWS)) u_hist_ram (
		.clk(clk), .we(cmd.wb), .waddr(row_q), .wdata({h0_eff, w_q}),
		.re(cmd.rd), .raddr(row_q), .rdata(hist_rd)
	);

	geq_ram #(.WIDTH(32), .DEPTH(ROWS)) u_gain_ram (
		.clk(clk), .we(we_gain), .waddr(gain_waddr), .wdata(item_q.value),
		.re(cmd.rd), .raddr(row_q), .rdata(gain_rd)
	);

	geq_ram #(.WIDTH(32), .DEPTH(MAX_BANDS)) u_a0_ram (
		.clk(clk), .we(we_a0), .waddr(coef_waddr), .wdata(item_q.value),
		.re(cmd.rd), .raddr(k_q), .rdata(a0_rd)
	);

	geq_ram #(.WIDTH(32), .DEPTH(MAX_BANDS)) u_a1_ram (
		.clk(clk), .we(we_a1), .waddr(coef_waddr), .wdata(item_q.value),
		.re(cmd.rd), .raddr(k_q), .rdata(a1_rd)
	);

	geq_ram #(.WIDTH(32), .DEPTH(MAX_BANDS)) u_b0_ram (
		.clk(clk), .we(we_b0), .waddr(coef_waddr), .wdata(item_q.value),
		.re(cmd.rd), .raddr(k_q), .rdata(b0_rd)
	);

	// Entries never written read as zero.
	assign h0_eff   = hist_rv_q ? hist_rd[39:0] : '0;
	assign h1_eff   = hist_rv_q ? hist_rd[79:40] : '0;
	assign gain_eff = gain_rv_q ? gain_rd : '0;
	assign a0_eff   = a0_rv_q ? a0_rd : '0;
	assign a1_eff   = a1_rv_q ? a1_rd : '0;
	assign b0_eff   = b0_rv_q ? b0_rd : '0;

	// Valid bits and their values sampled at each read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q <= '0;
			gain_valid_q <= '0;
			a0_valid_q   <= '0;
			a1_valid_q   <= '0;
			b0_valid_q   <= '0;
			hist_rv_q    <= 1'b0;
			gain_rv_q    <= 1'b0;
			a0_rv_q      <= 1'b0;
			a1_rv_q      <= 1'b0;
			b0_rv_q      <= 1'b0;
		end else begin
			if (cmd.wb) hist_valid_q[row_q] <= 1'b1;
			if (we_gain) gain_valid_q[gain_waddr] <= 1'b1;
			if (we_a0) a0_valid_q[coef_waddr] <= 1'b1;
			if (we_a1) a1_valid_q[coef_waddr] <= 1'b1;
			if (we_b0) b0_valid_q[coef_waddr] <= 1'b1;
			if (cmd.rd) begin
				hist_rv_q <= hist_valid_q[row_q];
				gain_rv_q <= gain_valid_q[row_q];
				a0_rv_q   <= a0_valid_q[k_q];
				a1_rv_q   <= a1_valid_q[k_q];
				b0_rv_q   <= b0_valid_q[k_q];
			end
		end
	end

	// Request capture and band register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bands_q <= '0;
		end else if (cfg_valid) begin
			active_bands_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// Multiplier operand selection.
	logic signed [39:0] op_a;
	logic signed [31:0] op_c;
	logic signed [23:0] op_a_hi;
	logic signed [16:0] op_a_lo;

	always_comb begin
		case (cmd.opa)
			geq_pkg::OPA_X:  op_a = x_q;
			geq_pkg::OPA_H0: op_a = h0_eff;
			geq_pkg::OPA_H1: op_a = h1_eff;
			geq_pkg::OPA_T:  op_a = t_q;
			default:         op_a = x_q;
		endcase
		case (cmd.opc)
			geq_pkg::OPC_B0:   op_c = b0_eff;
			geq_pkg::OPC_A0:   op_c = a0_eff;
			geq_pkg::OPC_A1:   op_c = a1_eff;
			geq_pkg::OPC_DAMP: op_c = geq_pkg::DAMP_COEF;
			geq_pkg::OPC_GAIN: op_c = gain_eff;
			default:           op_c = b0_eff;
		endcase
	end

	assign op_a_hi = op_a[39:16];
	assign op_a_lo = {1'b0, op_a[15:0]};

	// Stage 1: two partial products. Stage 2: combine and add rounding.
	always_ff @(posedge clk) begin
		lo_s1  <= op_a_lo * op_c;
		hi_s1  <= op_a_hi * op_c;
		sum_s2 <= (73'(hi_s1) <<< 16) + 73'(lo_s1) + ROUND_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= geq_pkg::TAG_NONE;
			tag_s2 <= geq_pkg::TAG_NONE;
		end else begin
			tag_s1 <= cmd.tag;
			tag_s2 <= tag_s1;
		end
	end

	// Product scaled back to Q9.30 and saturated.
	logic signed [44:0] prod_r;
	logic signed [39:0] prod_sat;
	logic               prod_ovf;
	logic signed [44:0] acc_sum, t_sum, x_sum;

	assign prod_r   = sum_s2[72:28];
	assign prod_ovf = geq_pkg::ovf40(prod_r);
	assign prod_sat = geq_pkg::sat40(prod_r);
	assign acc_sum  = 45'(acc_q) + 45'(prod_sat);
	assign t_sum    = 45'(w_q) + 45'(prod_sat);
	assign x_sum    = 45'(x_q) + 45'(prod_sat);

	// Product retirement into the band registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= {{9{item_q.sample_in[23]}}, item_q.sample_in, 7'b0};
		end
		case (tag_s2)
			geq_pkg::TAG_W0: acc_q <= 42'(prod_sat);
			geq_pkg::TAG_W1: acc_q <= acc_sum[41:0];
			geq_pkg::TAG_W2: w_q <= geq_pkg::sat40(acc_sum);
			geq_pkg::TAG_T:  t_q <= geq_pkg::sat40(t_sum);
			geq_pkg::TAG_X:  x_q <= geq_pkg::sat40(x_sum);
			default: ;
		endcase
	end

	// Clip flag and band position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
			k_q    <= '0;
			row_q  <= '0;
		end else begin
			if (cmd.start) begin
				clip_q <= 1'b0;
				k_q    <= '0;
				row_q  <= ch_row;
			end else if (tag_s2 != geq_pkg::TAG_NONE) begin
				case (tag_s2)
					geq_pkg::TAG_W2: clip_q <= clip_q | prod_ovf | geq_pkg::ovf40(acc_sum);
					geq_pkg::TAG_T:  clip_q <= clip_q | prod_ovf | geq_pkg::ovf40(t_sum);
					geq_pkg::TAG_X:  clip_q <= clip_q | prod_ovf | geq_pkg::ovf40(x_sum);
					default:         clip_q <= clip_q | prod_ovf;
				endcase
			end
			if (cmd.wb) begin
				k_q   <= k_q + 1'b1;
				row_q <= row_q + 1'b1;
			end
		end
	end

	// Output rounding and saturation to Q1.23.
	logic signed [40:0] y_sum;
	logic signed [33:0] y_r;
	logic               y_hi, y_lo;
	logic signed [23:0] y_sat;

	assign y_sum = 41'(x_q) + 41'sd64;
	assign y_r   = y_sum[40:7];
	assign y_hi  = y_r > 34'sd8388607;
	assign y_lo  = y_r < -34'sd8388608;
	assign y_sat = y_hi ? 24'sh7FFFFF : (y_lo ? 24'sh800000 : y_r[23:0]);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.sample_out  <= y_sat;
			out_q.out_channel <= item_q.channel;
			out_q.clipped     <= clip_q | y_hi | y_lo;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks.
	`GEQ_ASSERT_HOLDS(a_wb_pipe_empty, clk, arst_n, cmd.wb, tag_s1 == geq_pkg::TAG_NONE && tag_s2 == geq_pkg::TAG_NONE, "history written with products in flight")
	`GEQ_ASSERT_HOLDS(a_out_no_overwrite, clk, arst_n, cmd.out_load, !out_valid_q || out_ready, "output register overwritten")
	`GEQ_ASSERT_NEXT(a_w_then_t, clk, arst_n, tag_s2 == geq_pkg::TAG_W2, tag_s2 == geq_pkg::TAG_T, "damping product not behind w")
	`GEQ_ASSERT_HOLDS(a_issue_after_x, clk, arst_n, cmd.tag != geq_pkg::TAG_NONE, tag_s1 != geq_pkg::TAG_X && tag_s2 != geq_pkg::TAG_X, "product issued before x settled")

endmodule
